### rtl/led_pattern_animator_assert.svh
// Assertion macros shared by the LED pattern animator checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef LED_PATTERN_ANIMATOR_ASSERT_SVH
`define LED_PATTERN_ANIMATOR_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LPA_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("led_pattern_animator assertion failed");

// Checked on every rising edge, reset included.
`define LPA_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("led_pattern_animator assertion failed");

`endif

### rtl/lpa_pkg.sv
// Types and constants of the LED pattern animator.
// Used by lpa_animate and led_pattern_animator; depends on nothing.
package lpa_pkg;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_FADE   = 3'd1,
    MODE_PULSE  = 3'd2,
    MODE_FLASH  = 3'd3,
    MODE_ROTL   = 3'd4,
    MODE_ROTR   = 3'd5,
    MODE_BRIGHT = 3'd6
  } mode_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } op_t;

  localparam int unsigned DUTY_W = 15;

  localparam logic [7:0] PATTERN_RESET      = 8'hAA;
  localparam logic [7:0] LEVEL_TARGET_RESET = 8'hFF;
  localparam logic [7:0] PULSE_FLOOR_RESET  = 8'd25;
  localparam logic [7:0] START_COUNT        = 8'd5;
  localparam logic [DUTY_W-1:0] DUTY_SCALE  = 15'd88;

  typedef struct packed {
    logic [7:0] led_pattern;
    mode_t      anim_mode;
    logic [7:0] level;
    logic [7:0] level_target;
    logic       ramp_down;
  } anim_t;

  typedef struct packed {
    logic              fired;
    logic [7:0]        sent_pattern;
    logic [DUTY_W-1:0] pwm_duty;
    logic              timer_armed;
  } result_t;

endpackage

### rtl/lpa_animate.sv
// One animation step of the LED pattern animator: brightness ramps, flashing and pattern rotation.
// Depends on lpa_pkg.
module lpa_animate (
  input  lpa_pkg::anim_t cur,
  input  logic [7:0]     pulse_floor,
  output lpa_pkg::anim_t nxt,
  output logic           rearm
);
  import lpa_pkg::*;

  always_comb begin
    nxt   = cur;
    rearm = 1'b0;
    unique case (cur.anim_mode)
      MODE_NONE: begin
        nxt.level = cur.level_target;
      end
      MODE_FADE: begin
        if (cur.level < cur.level_target) begin
          nxt.level = cur.level + 8'd1;
          rearm     = 1'b1;
        end else if (cur.level > cur.level_target) begin
          nxt.level = cur.level - 8'd1;
          rearm     = 1'b1;
        end
      end
      MODE_PULSE: begin
        if (cur.ramp_down) begin
          if (cur.level > pulse_floor) begin
            nxt.level = cur.level - 8'd1;
          end else begin
            nxt.ramp_down = 1'b0;
          end
        end else begin
          if (cur.level < cur.level_target) begin
            nxt.level = cur.level + 8'd1;
          end else begin
            nxt.ramp_down = 1'b1;
          end
        end
        rearm = 1'b1;
      end
      MODE_FLASH: begin
        nxt.level = (cur.level == cur.level_target) ? 8'd0 : cur.level_target;
        rearm     = 1'b1;
      end
      MODE_ROTL: begin
        nxt.level       = cur.level_target;
        nxt.led_pattern = {cur.led_pattern[6:0], cur.led_pattern[7]};
        rearm           = 1'b1;
      end
      MODE_ROTR: begin
        nxt.level       = cur.level_target;
        nxt.led_pattern = {cur.led_pattern[0], cur.led_pattern[7:1]};
        rearm           = 1'b1;
      end
      default: begin
        rearm = 1'b0;
      end
    endcase
  end

endmodule

### rtl/led_pattern_animator.sv
// LED pattern animator top level: step timer, command decode and output buffering.
// Depends on lpa_pkg and lpa_animate.
//
// The input channel carries one beat per millisecond tick (operation 0) or per
// display command (operation 1). Every input beat yields exactly one output beat
// that tells whether an animation step fired, the pattern sent to the LEDs, the
// PWM duty and whether another step is scheduled.
// The result is held in the result register, or in the skid register while the
// receiver stalls. One beat per cycle is sustained while the receiver takes
// results: the whole step, including the level times 88 duty product, is a
// single pass of logic into the result register.
// A one-entry skid register sits behind the result register, so an input beat
// is still taken in the cycle the receiver first stalls. With both the result
// and the skid register full, in_ready drops until the receiver takes a beat.
// The pulse floor register is written through cfg_write_en and cfg_write_data
// and takes effect on the next beat.
// Reset empties both output registers, sets pattern 0xAA, mode none, level 0,
// target 255, pulse floor 25, ramp down, and arms a countdown of five ticks.
module led_pattern_animator #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [7:0]                 pattern,
  input  logic [2:0]                 mode,
  input  logic [15:0]                step_delay,
  input  logic [7:0]                 brightness,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       fired,
  output logic [7:0]                 sent_pattern,
  output logic [lpa_pkg::DUTY_W-1:0] pwm_duty,
  output logic                       timer_armed,
  input  logic                       cfg_write_en,
  input  logic [7:0]                 cfg_write_data
);
  import lpa_pkg::*;

  localparam int unsigned WIDE_BITS = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  anim_t                 anim;
  anim_t                 anim_next;
  anim_t                 anim_step;
  logic                  step_rearm;
  logic [DELAY_BITS-1:0] countdown;
  logic [DELAY_BITS-1:0] countdown_next;
  logic [DELAY_BITS-1:0] delay_ticks;
  logic [DELAY_BITS-1:0] delay_ticks_next;
  logic                  armed;
  logic                  armed_next;
  logic [7:0]            pulse_floor;
  result_t               res;
  result_t               out_res;
  result_t               skid_res;
  logic                  skid_valid;
  logic                  in_beat;
  logic [WIDE_BITS-1:0]  delay_wide;
  logic [WIDE_BITS-1:0]  delay_limit;
  logic [WIDE_BITS-1:0]  delay_sat;
  mode_t                 cmd_mode;

  lpa_animate u_animate (
    .cur         (anim),
    .pulse_floor (pulse_floor),
    .nxt         (anim_step),
    .rearm       (step_rearm)
  );

  assign in_ready = !skid_valid;
  assign in_beat  = in_valid && in_ready;
  assign cmd_mode = mode_t'(mode);

  assign delay_wide  = WIDE_BITS'(step_delay);
  assign delay_limit = WIDE_BITS'({DELAY_BITS{1'b1}});
  assign delay_sat   = (delay_wide > delay_limit) ? delay_limit : delay_wide;

  always_comb begin
    anim_next        = anim;
    countdown_next   = countdown;
    delay_ticks_next = delay_ticks;
    armed_next       = armed;
    res              = '0;
    if (op_t'(operation) == OP_CMD) begin
      if (cmd_mode != MODE_BRIGHT) begin
        anim_next.led_pattern = pattern;
        if (anim.anim_mode != MODE_PULSE) begin
          anim_next.ramp_down = 1'b1;
        end
        anim_next.anim_mode = cmd_mode;
        delay_ticks_next    = delay_sat[DELAY_BITS-1:0];
      end
      anim_next.level_target = brightness;
      countdown_next         = DELAY_BITS'(START_COUNT);
      armed_next             = 1'b1;
    end else if (armed) begin
      if (countdown <= DELAY_BITS'(1)) begin
        anim_next        = anim_step;
        armed_next       = step_rearm;
        countdown_next   = step_rearm ? delay_ticks : '0;
        res.fired        = 1'b1;
        res.sent_pattern = anim.led_pattern;
        res.pwm_duty     = DUTY_W'(anim_step.level) * DUTY_SCALE;
      end else begin
        countdown_next = countdown - DELAY_BITS'(1);
      end
    end
    res.timer_armed = armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim.led_pattern  <= PATTERN_RESET;
      anim.anim_mode    <= MODE_NONE;
      anim.level        <= '0;
      anim.level_target <= LEVEL_TARGET_RESET;
      anim.ramp_down    <= 1'b1;
      countdown         <= DELAY_BITS'(START_COUNT);
      delay_ticks       <= '0;
      armed             <= 1'b1;
    end else if (in_beat) begin
      anim        <= anim_next;
      countdown   <= countdown_next;
      delay_ticks <= delay_ticks_next;
      armed       <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_floor <= PULSE_FLOOR_RESET;
    end else if (cfg_write_en) begin
      pulse_floor <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_beat;
      end
    end else if (in_beat) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_beat) begin
        out_res <= res;
      end
    end else if (in_beat) begin
      skid_res <= res;
    end
  end

  assign fired        = out_res.fired;
  assign sent_pattern = out_res.sent_pattern;
  assign pwm_duty     = out_res.pwm_duty;
  assign timer_armed  = out_res.timer_armed;

endmodule

### rtl/lpa_checker.sv
// Port-level checker of the LED pattern animator and its bind to the top level.
// Depends on led_pattern_animator_assert.svh.
`include "led_pattern_animator_assert.svh"

module lpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        fired,
  input logic [7:0]  sent_pattern,
  input logic [14:0] pwm_duty,
  input logic        timer_armed
);

  // A held result must stay offered, unchanged, until the receiver takes it.
  `LPA_ASSERT(a_out_hold, clk, rst,
              out_valid && !out_ready |=> out_valid && $stable(fired) &&
              $stable(sent_pattern) && $stable(pwm_duty) && $stable(timer_armed))
  // The block leaves reset with an empty output and an open input.
  `LPA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready)
  // The input only closes while a result is waiting at the output.
  `LPA_ASSERT(a_ready_backpressure, clk, rst, !in_ready |-> out_valid)
  // Every accepted input beat leaves a result on offer in the next cycle.
  `LPA_ASSERT(a_beat_answered, clk, rst, in_valid && in_ready |=> out_valid)
  // A beat without a step carries no pattern and no duty.
  `LPA_ASSERT(a_idle_result_zero, clk, rst,
              out_valid && !fired |-> sent_pattern == 8'd0 && pwm_duty == 15'd0)

endmodule

bind led_pattern_animator lpa_checker u_lpa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .fired        (fired),
  .sent_pattern (sent_pattern),
  .pwm_duty     (pwm_duty),
  .timer_armed  (timer_armed)
);
